### hw/rtl/variable_record_store_assert.svh
// Assertion macros for the record store
`ifndef VARIABLE_RECORD_STORE_ASSERT_SVH
`define VARIABLE_RECORD_STORE_ASSERT_SVH

// property checked on every clock edge outside reset
`define VRS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define VRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/vrs_pkg.sv
`default_nettype none
package vrs_pkg;
  localparam int unsigned MemBytes = 1024;
  localparam int unsigned AddrW = $clog2(MemBytes);
  localparam int unsigned LvlW = AddrW + 1;
  localparam int unsigned MaxRecLen = 15;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    REQ_STORE = 2'd0,
    REQ_FIND  = 2'd1,
    REQ_ERASE = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_NOROOM   = 2'd2
  } status_e;

  // one classified command between front and back
  typedef struct packed {
    req_e        req;
    logic [7:0]  head;
    logic [31:0] seconds;
    logic [MaxRecLen*8-1:0] bytes;  // record image, byte 0 in low bits
    logic [3:0]  len;
    logic [AddrW-1:0] position;
  } cmd_t;

  function automatic logic [3:0] rec_len(input logic [2:0] t);
    logic [3:0] l;
    case (t)
      3'd0: l = 4'd5;
      3'd1: l = 4'd6;
      3'd2: l = 4'd8;
      3'd3: l = 4'd10;
      3'd4: l = 4'd10;
      3'd5: l = 4'd13;
      3'd6: l = 4'd12;
      default: l = 4'd15;
    endcase
    return l;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/vrs_front.sv
`default_nettype none
// Front: packs a request into a command with its record image
module vrs_front import vrs_pkg::*; (
  input  wire logic        req_i,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  head_i,
  input  wire logic [31:0] seconds_i,
  input  wire logic [7:0]  seconds_millis_i,
  input  wire logic [15:0] interval_i,
  input  wire logic [7:0]  interval_millis_i,
  input  wire logic [15:0] frequency_i,
  input  wire logic [7:0]  frequency_millis_i,
  input  wire logic [15:0] repeat_count_i,
  input  wire logic [7:0]  extended_i,
  input  wire logic [9:0]  position_i,
  output cmd_t             cmd_o,
  output logic             push_o
);
  logic [2:0] t;
  logic [7:0] b [MaxRecLen];
  logic [3:0] p;

  assign t = head_i[7:5];
  assign push_o = req_i;

  // lay out bytes in record order, optional fields per type
  always_comb begin
    for (int i = 0; i < MaxRecLen; i++) b[i] = 8'h00;
    b[0] = head_i;
    b[1] = seconds_i[31:24];
    b[2] = seconds_i[23:16];
    b[3] = seconds_i[15:8];
    b[4] = seconds_i[7:0];
    p = 4'd5;
    if (t[0]) begin b[p] = seconds_millis_i; p = p + 4'd1; end
    if (t >= 3'd2) begin
      b[p] = interval_i[15:8]; b[p+4'd1] = interval_i[7:0]; p = p + 4'd2;
    end
    if (t == 3'd3 || t == 3'd5 || t == 3'd7) begin
      b[p] = interval_millis_i; p = p + 4'd1;
    end
    if (t >= 3'd4) begin
      b[p] = frequency_i[15:8]; b[p+4'd1] = frequency_i[7:0]; p = p + 4'd2;
    end
    if (t == 3'd5 || t == 3'd7) begin b[p] = frequency_millis_i; p = p + 4'd1; end
    if (t >= 3'd6) begin
      b[p] = repeat_count_i[15:8]; b[p+4'd1] = repeat_count_i[7:0]; p = p + 4'd2;
    end
    if (t >= 3'd2) begin b[p] = extended_i; end
  end

  always_comb begin
    cmd_o.req = req_e'(req_type_i);
    cmd_o.head = head_i;
    cmd_o.seconds = seconds_i;
    for (int i = 0; i < MaxRecLen; i++) cmd_o.bytes[i*8 +: 8] = b[i];
    cmd_o.len = rec_len(t);
    cmd_o.position = position_i[AddrW-1:0];
  end
endmodule
`default_nettype wire

### hw/rtl/vrs_queue.sv
`default_nettype none
// Short command queue between front and back
module vrs_queue import vrs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output logic      empty_o,
  output logic      full_o
);
  localparam int unsigned PW = $clog2(QDepth);
  cmd_t slot_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o = (cnt_q == (PW+1)'(QDepth));
  assign cmd_o = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + PW'(1);
      if (pop_i) rp_q <= rp_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

### hw/rtl/vrs_back.sv
`default_nettype none
// Back: executes commands on the byte memory, at most one byte access per cycle
module vrs_back import vrs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  cmd_t             cmd_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  output logic             idle_o,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [LvlW-1:0]  offset_o,
  output logic [LvlW-1:0]  fill_level_o,
  output logic             full_res_o
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WR    = 4'd1;
  localparam logic [3:0] S_FRD   = 4'd2;
  localparam logic [3:0] S_FCMP  = 4'd3;
  localparam logic [3:0] S_ERD   = 4'd4;
  localparam logic [3:0] S_ELEN  = 4'd5;
  localparam logic [3:0] S_SRD   = 4'd6;
  localparam logic [3:0] S_SWR   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_CLR   = 4'd9;

  logic [7:0] mem [MemBytes];
  logic [7:0] rd_q;
  logic [3:0] st_q;
  cmd_t c_q;
  logic [LvlW-1:0] used_q, ptr_q, rec_q, len_q;
  logic [3:0] k_q;
  logic [7:0] h_q;
  logic [31:0] s_q;
  logic [1:0] status_q;
  logic [LvlW-1:0] offset_q;

  logic            we, re;
  logic [AddrW-1:0] wa, ra;
  logic [7:0]      wd;

  assign idle_o = (st_q == S_IDLE);
  assign pop_o = idle_o && !empty_i;
  assign done_o = (st_q == S_DONE);
  assign status_o = status_q;
  assign offset_o = offset_q;
  assign fill_level_o = used_q;
  assign full_res_o = ({1'b0, used_q} + (LvlW+1)'(MaxRecLen)) > (LvlW+1)'(MemBytes);

  // memory port select
  always_comb begin
    we = 1'b0; re = 1'b0; wa = ptr_q[AddrW-1:0]; ra = ptr_q[AddrW-1:0]; wd = 8'h00;
    unique case (st_q)
      S_WR: begin we = 1'b1; wd = c_q.bytes[k_q*8 +: 8]; end
      S_FRD, S_ERD: re = 1'b1;
      S_SRD: begin re = 1'b1; ra = AddrW'(ptr_q + len_q); end
      S_SWR: begin we = 1'b1; wd = rd_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && !empty_i) c_q <= cmd_i;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; used_q <= '0; ptr_q <= '0; rec_q <= '0; len_q <= '0;
      k_q <= '0; h_q <= '0; s_q <= '0; status_q <= ST_OK; offset_q <= '0;
    end else begin
      unique case (st_q)
        S_IDLE: if (!empty_i) begin
          k_q <= '0; rec_q <= '0;
          unique case (cmd_i.req)
            REQ_STORE: begin
              offset_q <= used_q;
              if ({1'b0, used_q} + (LvlW+1)'(cmd_i.len) > (LvlW+1)'(MemBytes)) begin
                status_q <= ST_NOROOM; st_q <= S_DONE;
              end else begin
                status_q <= ST_OK; ptr_q <= used_q; st_q <= S_WR;
              end
            end
            REQ_FIND: begin
              ptr_q <= '0;
              if (used_q == '0) begin
                status_q <= ST_NOTFOUND; offset_q <= used_q; st_q <= S_DONE;
              end else begin
                status_q <= ST_OK; st_q <= S_FRD;
              end
            end
            REQ_ERASE: begin
              if (LvlW'(cmd_i.position) >= used_q) begin
                status_q <= ST_NOTFOUND; offset_q <= used_q; st_q <= S_DONE;
              end else begin
                status_q <= ST_OK;
                ptr_q <= LvlW'(cmd_i.position); offset_q <= LvlW'(cmd_i.position);
                st_q <= S_ERD;
              end
            end
            default: begin
              status_q <= ST_OK; used_q <= '0; offset_q <= '0; st_q <= S_DONE;
            end
          endcase
        end
        S_WR: begin
          ptr_q <= ptr_q + LvlW'(1); k_q <= k_q + 4'd1;
          if (k_q + 4'd1 == c_q.len) begin
            used_q <= ptr_q + LvlW'(1); st_q <= S_DONE;
          end
        end
        // read byte rec_q+k_q, compare after five bytes
        S_FRD: begin
          ptr_q <= rec_q + LvlW'(k_q); st_q <= S_FCMP;
        end
        S_FCMP: begin
          if (k_q == 4'd0) h_q <= rd_q; else s_q <= {s_q[23:0], rd_q};
          if (k_q == 4'd0 &&
              ({1'b0, rec_q} + (LvlW+1)'(5) > {1'b0, used_q})) begin
            status_q <= ST_NOTFOUND; offset_q <= used_q; st_q <= S_DONE;
          end else if (k_q == 4'd4) begin
            if (h_q == c_q.head && {s_q[23:0], rd_q} == c_q.seconds) begin
              offset_q <= rec_q; st_q <= S_DONE;
            end else if ({1'b0, rec_q} + (LvlW+1)'(rec_len(h_q[7:5]))
                         >= {1'b0, used_q}) begin
              status_q <= ST_NOTFOUND; offset_q <= used_q; st_q <= S_DONE;
            end else begin
              rec_q <= rec_q + LvlW'(rec_len(h_q[7:5])); k_q <= '0;
              ptr_q <= rec_q + LvlW'(rec_len(h_q[7:5])); st_q <= S_FRD;
            end
          end else begin
            k_q <= k_q + 4'd1; ptr_q <= rec_q + LvlW'(k_q) + LvlW'(1); st_q <= S_FRD;
          end
        end
        S_ERD: st_q <= S_ELEN;
        S_ELEN: begin
          if (ptr_q + LvlW'(rec_len(rd_q[7:5])) >= used_q) begin
            used_q <= ptr_q; st_q <= S_DONE;
          end else begin
            len_q <= LvlW'(rec_len(rd_q[7:5])); st_q <= S_SRD;
          end
        end
        S_SRD: st_q <= S_SWR;
        S_SWR: begin
          if (ptr_q + len_q + LvlW'(1) >= used_q) begin
            used_q <= used_q - len_q; st_q <= S_DONE;
          end else begin
            ptr_q <= ptr_q + LvlW'(1); st_q <= S_SRD;
          end
        end
        S_DONE: st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/variable_record_store.sv
// Store writes the record byte by byte, find reads the head and seconds of each
// scanned record, erase shifts the later bytes down (one memory port).
// Throughput: one request at a time through the back end; up to two queue.
// Reset: asynchronous active low; fill level clears, memory contents are not.
// Results appear for one cycle on done_o; the receiver cannot stall.
`default_nettype none
module variable_record_store import vrs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  head_i,
  input  wire logic [31:0] seconds_i,
  input  wire logic [7:0]  seconds_millis_i,
  input  wire logic [15:0] interval_i,
  input  wire logic [7:0]  interval_millis_i,
  input  wire logic [15:0] frequency_i,
  input  wire logic [7:0]  frequency_millis_i,
  input  wire logic [15:0] repeat_count_i,
  input  wire logic [7:0]  extended_i,
  input  wire logic [9:0]  position_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [10:0]      offset_o,
  output logic [10:0]      fill_level_o,
  output logic             full_res_o
);
`include "variable_record_store_assert.svh"
  cmd_t fcmd, qcmd;
  logic push, pop, empty, full, idle;

  vrs_front u_front (
    .req_i(start && !busy), .req_type_i, .head_i, .seconds_i, .seconds_millis_i,
    .interval_i, .interval_millis_i, .frequency_i, .frequency_millis_i,
    .repeat_count_i, .extended_i, .position_i, .cmd_o(fcmd), .push_o(push)
  );

  vrs_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(fcmd), .pop_i(pop), .cmd_o(qcmd),
    .empty_o(empty), .full_o(full)
  );

  vrs_back u_back (
    .clk_i, .rst_ni, .cmd_i(qcmd), .empty_i(empty), .pop_o(pop), .idle_o(idle),
    .done_o, .status_o, .offset_o, .fill_level_o, .full_res_o
  );

  assign busy = full;

  `VRS_ASSERT(a_fill_range, clk_i, rst_ni, fill_level_o <= 11'd1024, "fill above size")
  `VRS_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "done held two cycles")
  `VRS_ASSERT(a_done_idle, clk_i, rst_ni, !(done_o && idle), "done while idle")
endmodule
`default_nettype wire

### sim/variable_record_store_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Watches request and result transfers, keeps a byte image of the store
// and compares every result with the oldest outstanding prediction.
module variable_record_store_checker import vrs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [7:0]  head_i,
  input  wire logic [31:0] seconds_i,
  input  wire logic [7:0]  seconds_millis_i,
  input  wire logic [15:0] interval_i,
  input  wire logic [7:0]  interval_millis_i,
  input  wire logic [15:0] frequency_i,
  input  wire logic [7:0]  frequency_millis_i,
  input  wire logic [15:0] repeat_count_i,
  input  wire logic [7:0]  extended_i,
  input  wire logic [9:0]  position_i,
  input  wire logic        done_i,
  input  wire logic [1:0]  status_i,
  input  wire logic [10:0] offset_i,
  input  wire logic [10:0] fill_level_i,
  input  wire logic        full_res_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               fill_o
);

  typedef struct packed {
    status_e     status;
    logic [10:0] offset;
    logic [10:0] fill;
    logic        full;
  } reply_t;

  localparam int unsigned RecBytes [8] = '{5, 6, 8, 10, 10, 13, 12, 15};

  logic [7:0] image [MemBytes];
  int unsigned used;
  reply_t replies_q [$];

  // append one byte to a record being built
  task automatic put(inout int unsigned p, input logic [7:0] b);
    image[p] = b;
    p++;
  endtask

  task automatic predict_request();
    reply_t r;
    int unsigned t, len, p, idx, s;
    logic hit;
    r.status = ST_OK;
    r.offset = '0;
    case (req_e'(req_type_i))
      REQ_STORE: begin
        t = head_i[7:5];
        len = RecBytes[t];
        if (used + len > MemBytes) begin
          r.status = ST_NOROOM;
          r.offset = 11'(used);
        end else begin
          p = used;
          r.offset = 11'(p);
          put(p, head_i);
          put(p, seconds_i[31:24]);
          put(p, seconds_i[23:16]);
          put(p, seconds_i[15:8]);
          put(p, seconds_i[7:0]);
          if (t[0]) put(p, seconds_millis_i);
          if (t >= 2) begin
            put(p, interval_i[15:8]);
            put(p, interval_i[7:0]);
          end
          if (t == 3 || t == 5 || t == 7) put(p, interval_millis_i);
          if (t >= 4) begin
            put(p, frequency_i[15:8]);
            put(p, frequency_i[7:0]);
          end
          if (t == 5 || t == 7) put(p, frequency_millis_i);
          if (t >= 6) begin
            put(p, repeat_count_i[15:8]);
            put(p, repeat_count_i[7:0]);
          end
          if (t >= 2) put(p, extended_i);
          used = p;
        end
      end
      REQ_FIND: begin
        // walk record heads; a record with under five bytes below the fill level never matches
        idx = 0;
        hit = 1'b0;
        while (idx < used && !hit) begin
          if (idx + 5 <= used) begin
            s = {image[idx+1], image[idx+2], image[idx+3], image[idx+4]};
            if (image[idx] == head_i && s == seconds_i) hit = 1'b1;
          end
          if (!hit) idx += RecBytes[image[idx][7:5]];
        end
        r.status = hit ? ST_OK : ST_NOTFOUND;
        r.offset = hit ? 11'(idx) : 11'(used);
      end
      REQ_ERASE: begin
        p = position_i;
        if (p >= used) begin
          r.status = ST_NOTFOUND;
          r.offset = 11'(used);
        end else begin
          // a record running past the fill level loses only its stored bytes
          len = RecBytes[image[p][7:5]];
          if (p + len > used) len = used - p;
          for (int unsigned i = p; i + len < used; i++) image[i] = image[i+len];
          used -= len;
          r.offset = 11'(p);
        end
      end
      default: begin
        for (int unsigned i = 0; i < used; i++) image[i] = '0;
        used = 0;
      end
    endcase
    r.fill = 11'(used);
    r.full = (used + 15 > MemBytes);
    replies_q.push_back(r);
  endtask

  assign pending_o = replies_q.size();
  assign fill_o = used;

  initial begin
    fail_count_o = 0;
    used = 0;
  end

  // results first: a reply never belongs to the request of the same edge
  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni) begin
      if (done_i) begin
        if (replies_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result: status %0d offset %0d fill %0d full %0d",
                     status_i, offset_i, fill_level_i, full_res_i);
        end else begin
          e = replies_q.pop_front();
          if (status_i !== e.status || offset_i !== e.offset ||
              fill_level_i !== e.fill || full_res_i !== e.full) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: exp st %0d off %0d fill %0d full %0d, got %0d %0d %0d %0d",
                       e.status, e.offset, e.fill, e.full,
                       status_i, offset_i, fill_level_i, full_res_i);
          end
        end
      end
      if (start_i && !busy_i) predict_request();
    end
  end

endmodule
`default_nettype wire

### sim/variable_record_store_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module variable_record_store_tb;
  import vrs_pkg::*;

  localparam int StallLimit = 50000;
  localparam int NumRandom = 560;

  typedef struct {
    req_e        req;
    logic [7:0]  head;
    logic [31:0] secs;
    logic [7:0]  sec_ms;
    logic [15:0] ivl;
    logic [7:0]  ivl_ms;
    logic [15:0] freq;
    logic [7:0]  freq_ms;
    logic [15:0] reps;
    logic [7:0]  ext;
    logic [9:0]  pos;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type_i = '0;
  logic [7:0] head_i = '0;
  logic [31:0] seconds_i = '0;
  logic [7:0] seconds_millis_i = '0;
  logic [15:0] interval_i = '0;
  logic [7:0] interval_millis_i = '0;
  logic [15:0] frequency_i = '0;
  logic [7:0] frequency_millis_i = '0;
  logic [15:0] repeat_count_i = '0;
  logic [7:0] extended_i = '0;
  logic [9:0] position_i = '0;
  logic done_o, full_res_o;
  logic [1:0] status_o;
  logic [10:0] offset_o, fill_level_o;
  int fail_count, pending, fill;
  int stall_cycles = 0;
  int idle_pct = 38;
  logic [7:0] heads_q [$];
  logic [31:0] secs_q [$];

  variable_record_store uut (.*);

  variable_record_store_checker checker_i (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .req_type_i, .head_i,
    .seconds_i, .seconds_millis_i, .interval_i, .interval_millis_i, .frequency_i,
    .frequency_millis_i, .repeat_count_i, .extended_i, .position_i,
    .done_i(done_o), .status_i(status_o), .offset_i(offset_o),
    .fill_level_i(fill_level_o), .full_res_i(full_res_o),
    .fail_count_o(fail_count), .pending_o(pending), .fill_o(fill)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // watchdog: cycles with neither a request nor a result transfer
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // present one request and hold it until the block takes it
  task automatic issue(input request_t r);
    @(negedge clk_i);
    start = 1'b1;
    req_type_i = r.req;
    head_i = r.head;
    seconds_i = r.secs;
    seconds_millis_i = r.sec_ms;
    interval_i = r.ivl;
    interval_millis_i = r.ivl_ms;
    frequency_i = r.freq;
    frequency_millis_i = r.freq_ms;
    repeat_count_i = r.reps;
    extended_i = r.ext;
    position_i = r.pos;
    do @(posedge clk_i); while (busy);
    if (r.req == REQ_STORE) begin
      heads_q.push_back(r.head);
      secs_q.push_back(r.secs);
      if (heads_q.size() > 16) begin
        void'(heads_q.pop_front());
        void'(secs_q.pop_front());
      end
    end
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
    end
  endtask

  function automatic request_t payload(input req_e q, input logic [7:0] h,
                                       input logic [31:0] s, input logic [9:0] p);
    request_t r;
    r.req = q;
    r.head = h;
    r.secs = s;
    r.sec_ms = 8'($urandom);
    r.ivl = 16'($urandom);
    r.ivl_ms = 8'($urandom);
    r.freq = 16'($urandom);
    r.freq_ms = 8'($urandom);
    r.reps = 16'($urandom);
    r.ext = 8'($urandom);
    r.pos = p;
    return r;
  endfunction

  // random request; clears are withheld in one stretch so the store fills up
  function automatic request_t random_request(input int n);
    int sel, k;
    logic [31:0] s;
    request_t r;
    sel = $urandom_range(99);
    s = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom;
    if (n >= 200 && n < 330) sel = (sel < 80) ? 0 : sel;
    if (sel < 55) begin
      r = payload(REQ_STORE, 8'($urandom), s, 10'($urandom));
    end else if (sel < 75) begin
      r = payload(REQ_FIND, 8'($urandom), s, 10'($urandom));
      if (heads_q.size() > 0 && $urandom_range(9) < 7) begin
        k = $urandom_range(heads_q.size() - 1);
        r.head = heads_q[k];
        r.secs = secs_q[k];
        if ($urandom_range(9) == 0) r.secs[$urandom_range(31)] ^= 1'b1;
      end
    end else if (sel < 93 || (n >= 200 && n < 330)) begin
      r = payload(REQ_ERASE, 8'($urandom), s, 10'($urandom));
      case ($urandom_range(3))
        0: r.pos = '0;
        1: r.pos = 10'($urandom);
        default: r.pos = 10'($urandom_range(fill + 4));
      endcase
    end else begin
      r = payload(REQ_CLEAR, 8'($urandom), s, 10'($urandom));
    end
    return r;
  endfunction

  initial begin
    request_t r;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: each record type, field extremes, hits, misses, erase cases
    issue(payload(REQ_CLEAR, 8'h00, 32'h0, 10'h0));
    for (int t = 0; t < 8; t++) begin
      r = payload(REQ_STORE, {3'(t), 5'h00}, 32'h0, 10'h0);
      if (t[0]) begin
        r = '{REQ_STORE, {3'(t), 5'h1f}, 32'hffff_ffff, 8'hff, 16'hffff, 8'hff,
              16'hffff, 8'hff, 16'hffff, 8'hff, 10'h3ff};
      end else begin
        r = '{REQ_STORE, {3'(t), 5'h00}, 32'h0, 8'h0, 16'h0, 8'h0,
              16'h0, 8'h0, 16'h0, 8'h0, 10'h0};
      end
      issue(r);
    end
    issue(payload(REQ_FIND, 8'hff, 32'hffff_ffff, 10'h0));
    issue(payload(REQ_FIND, 8'h40, 32'h0, 10'h0));
    issue(payload(REQ_FIND, 8'h40, 32'h1, 10'h0));
    issue(payload(REQ_FIND, 8'h00, 32'h0, 10'h0));
    issue(payload(REQ_ERASE, 8'h00, 32'h0, 10'h3ff));
    issue(payload(REQ_ERASE, 8'h00, 32'h0, 10'd0));
    issue(payload(REQ_ERASE, 8'h00, 32'h0, 10'd7));
    issue(payload(REQ_FIND, 8'hff, 32'hffff_ffff, 10'h0));
    issue(payload(REQ_ERASE, 8'h00, 32'h0, 10'(fill - 1)));
    issue(payload(REQ_STORE, 8'he0, 32'h1234_5678, 10'h0));
    issue(payload(REQ_ERASE, 8'h00, 32'h0, 10'(fill - 3)));
    issue(payload(REQ_CLEAR, 8'h00, 32'h0, 10'h0));
    issue(payload(REQ_FIND, 8'h00, 32'h0, 10'h0));
    issue(payload(REQ_ERASE, 8'h00, 32'h0, 10'h0));

    // random traffic in three idling phases
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) idle_pct = 54;
      if (n == 2 * NumRandom / 3) idle_pct = 0;
      issue(random_request(n));
    end
    @(negedge clk_i);
    start = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
